[design/cie_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_pkg
// shared types and constants of the calculator instruction execute core
// ----------------------------------------------------------------------------
package cie_pkg;

   localparam int NUM_REGS_DEF   = 10;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int LINE_WIDTH_DEF = 16;
   localparam int FUNC_W         = 4;
   localparam int REG_W          = 4;
   localparam int IMM_W          = 32;
   localparam int ERR_W          = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_ADD  = 4'd0,
      FN_SUB  = 4'd1,
      FN_MUL  = 4'd2,
      FN_DIV  = 4'd3,
      FN_GCD  = 4'd4,
      FN_CMP  = 4'd5,
      FN_MOVE = 4'd6,
      FN_JUMP = 4'd7,
      FN_BR   = 4'd8,
      FN_HALT = 4'd9
   } func_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_DIV0  = 2'd1,
      ERR_INDEX = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ITER,
      ST_FINISH,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request word
      logic decode;    // read operands, set up unit
      logic step;      // one iteration of div or gcd
      logic finish;    // form result, update state
      logic send;      // result word handed off
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_iter;
      logic iter_done;
   } stat_type;

endpackage

[design/cie_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_req_if / cie_rsp_if
// valid/ready channels of the calculator instruction execute core
// ----------------------------------------------------------------------------
interface cie_req_if;
   logic                   valid;
   logic                   ready;
   logic [3:0]             func;
   logic                   a_is_reg;
   logic signed [31:0]     a_imm;
   logic [3:0]             a_reg;
   logic                   b_is_reg;
   logic signed [31:0]     b_imm;
   logic [3:0]             b_reg;
   modport source (output valid, func, a_is_reg, a_imm, a_reg, b_is_reg, b_imm, b_reg,
                   input ready);
   modport sink (input valid, func, a_is_reg, a_imm, a_reg, b_is_reg, b_imm, b_reg,
                 output ready);
endinterface

interface cie_rsp_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     result;
   logic [3:0]             dest_reg;
   logic                   wrote_reg;
   logic [15:0]            next_line;
   logic                   jumped;
   logic                   halted;
   logic [1:0]             error_code;
   modport source (output valid, result, dest_reg, wrote_reg, next_line, jumped, halted,
                   error_code, input ready);
   modport sink (input valid, result, dest_reg, wrote_reg, next_line, jumped, halted,
                 error_code, output ready);
endinterface

[design/calc_instruction_execute_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calc_instruction_execute_core
// executes one decoded calculator instruction per word
//
//  channel  dir  signals
//  req      in   valid ready func a_is_reg a_imm a_reg b_is_reg b_imm b_reg
//  rsp      out  valid ready result dest_reg wrote_reg next_line jumped
//                halted error_code
//
// simple ops: accept, decode, iter (no steps), finish, then the result word is held until taken
// div: iterates in the shift-subtract unit
// gcd: iterates one full division per euclid remainder step on the same unit
// synchronous reset clears registers, line counter and halt flag at once
// one word in flight; req_ready is low until the result word is taken
// ----------------------------------------------------------------------------
module calc_instruction_execute_core #(
   parameter int NUM_REGS   = cie_pkg::NUM_REGS_DEF,
   parameter int DATA_WIDTH = cie_pkg::DATA_WIDTH_DEF,
   parameter int LINE_WIDTH = cie_pkg::LINE_WIDTH_DEF
) (
   input logic     clock,
   input logic     reset,
   cie_req_if.sink   req,
   cie_rsp_if.source rsp
);
   import cie_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cie_dpath #(
      .NUM_REGS   (NUM_REGS),
      .DATA_WIDTH (DATA_WIDTH),
      .LINE_WIDTH (LINE_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_func        (req.func),
      .in_a_is_reg    (req.a_is_reg),
      .in_a_imm       (req.a_imm),
      .in_a_reg       (req.a_reg),
      .in_b_is_reg    (req.b_is_reg),
      .in_b_imm       (req.b_imm),
      .in_b_reg       (req.b_reg),
      .out_result     (rsp.result),
      .out_dest_reg   (rsp.dest_reg),
      .out_wrote_reg  (rsp.wrote_reg),
      .out_next_line  (rsp.next_line),
      .out_jumped     (rsp.jumped),
      .out_halted     (rsp.halted),
      .out_error_code (rsp.error_code)
   );
endmodule

[design/cie_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_ctrl
// sequencer: accept, decode, iterate, finish, send
// ----------------------------------------------------------------------------
module cie_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  cie_pkg::stat_type stat,
   output cie_pkg::cmd_type  cmd
);
   import cie_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_ITER;
         end
         ST_ITER: begin
            if (stat.needs_iter && !stat.iter_done) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.send = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.decode, cmd.step, cmd.finish, cmd.send}))
      else $error("more than one command");
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finish not followed by result");
   a_load_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.decode)
      else $error("load not followed by decode");
endmodule

[design/cie_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_dpath
// register file, line counter, operand select, bit-serial divider and gcd
// ----------------------------------------------------------------------------
module cie_dpath #(
   parameter int NUM_REGS   = cie_pkg::NUM_REGS_DEF,
   parameter int DATA_WIDTH = cie_pkg::DATA_WIDTH_DEF,
   parameter int LINE_WIDTH = cie_pkg::LINE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cie_pkg::cmd_type      cmd,
   output cie_pkg::stat_type     stat,
   input  logic [3:0]            in_func,
   input  logic                  in_a_is_reg,
   input  logic [31:0]           in_a_imm,
   input  logic [3:0]            in_a_reg,
   input  logic                  in_b_is_reg,
   input  logic [31:0]           in_b_imm,
   input  logic [3:0]            in_b_reg,
   output logic [31:0]           out_result,
   output logic [3:0]            out_dest_reg,
   output logic                  out_wrote_reg,
   output logic [15:0]           out_next_line,
   output logic                  out_jumped,
   output logic                  out_halted,
   output logic [1:0]            out_error_code
);
   import cie_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int LW = LINE_WIDTH;
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] rf_ff [NUM_REGS];
   logic [LW-1:0] line_ff;
   logic          halt_ff;

   // captured request
   logic [3:0]    func_ff, a_reg_ff, b_reg_ff;
   logic          a_is_reg_ff, b_is_reg_ff;
   logic [31:0]   a_imm_ff, b_imm_ff;

   // decoded operands
   logic [DW-1:0] a_ff, b_ff, prod_ff;
   logic          bad_ff, mbad_ff, abad_ff;

   // iterative unit: shift-subtract divider, then euclid via the same divider
   logic [DW-1:0] rem_ff, quo_ff, dvd_ff, dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, gcd_mode_ff, done_ff;
   logic [DW-1:0] gx_ff, gy_ff;

   // output word
   logic [31:0]   res_ff;
   logic [3:0]    dest_ff;
   logic          wrote_ff, jumped_ff;
   logic [LW-1:0] next_ff;
   logic [1:0]    err_ff;

   function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
      return v[DW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [DW-1:0] ext(input logic [31:0] v);
      logic [63:0] w;
      w = {{32{v[31]}}, v};
      return w[DW-1:0];
   endfunction

   logic          a_bad, b_bad;
   logic [DW-1:0] a_val, b_val;
   logic [DW:0]   trial;
   logic [DW-1:0] rem_sh, rem_nx;

   always_comb begin
      a_bad = a_is_reg_ff && (32'(a_reg_ff) >= NUM_REGS);
      b_bad = b_is_reg_ff && (32'(b_reg_ff) >= NUM_REGS);
      a_val = ext(a_imm_ff);
      b_val = ext(b_imm_ff);
      if (a_is_reg_ff) begin
         a_val = a_bad ? '0 : rf_ff[a_reg_ff[$clog2(NUM_REGS)-1:0]];
      end
      if (b_is_reg_ff) begin
         b_val = b_bad ? '0 : rf_ff[b_reg_ff[$clog2(NUM_REGS)-1:0]];
      end
      rem_sh = {rem_ff[DW-2:0], dvd_ff[DW-1]};
      trial  = {1'b0, rem_sh} - {1'b0, dvs_ff};
      rem_nx = trial[DW] ? rem_sh : trial[DW-1:0];
   end

   assign stat.needs_iter = busy_ff;
   assign stat.iter_done  = done_ff;

   logic [DW-1:0] fin_res;
   logic          fin_wrote, fin_jump;
   logic [1:0]    fin_err;
   logic [3:0]    fin_dest;
   logic [LW-1:0] line_inc, next_inc, target;
   logic          r0_one;

   always_comb begin
      fin_res   = '0;
      fin_wrote = 1'b0;
      fin_jump  = 1'b0;
      fin_err   = ERR_NONE;
      fin_dest  = '0;
      line_inc  = line_ff + 1'b1;
      next_inc  = line_inc + 1'b1;
      target    = LW'(a_ff);
      r0_one    = (rf_ff[0] == DW'(1));
      case (func_ff)
         FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_GCD, FN_CMP: begin
            if (bad_ff) begin
               fin_err = ERR_INDEX;
            end else begin
               fin_wrote = 1'b1;
               case (func_ff)
                  FN_ADD: fin_res = a_ff + b_ff;
                  FN_SUB: fin_res = a_ff - b_ff;
                  FN_MUL: fin_res = prod_ff;
                  FN_DIV: begin
                     if (b_ff == '0) begin
                        fin_err   = ERR_DIV0;
                        fin_wrote = 1'b0;
                     end else begin
                        fin_res = (a_ff[DW-1] ^ b_ff[DW-1]) ? (~quo_ff + 1'b1) : quo_ff;
                     end
                  end
                  FN_GCD: fin_res = gx_ff;
                  default: fin_res = ($signed(a_ff) >= $signed(b_ff)) ? '0 : DW'(1);
               endcase
            end
         end
         FN_MOVE: begin
            if (mbad_ff) begin
               fin_err = ERR_INDEX;
            end else begin
               fin_wrote = 1'b1;
               fin_res   = rf_ff[b_reg_ff[$clog2(NUM_REGS)-1:0]];
               fin_dest  = a_reg_ff;
            end
         end
         FN_JUMP, FN_BR: begin
            if (abad_ff) begin
               fin_err = ERR_INDEX;
            end else if (func_ff == FN_JUMP || r0_one) begin
               fin_jump = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) rf_ff[i] <= '0;
         line_ff     <= '0;
         halt_ff     <= 1'b0;
         busy_ff     <= 1'b0;
         done_ff     <= 1'b0;
         gcd_mode_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b0;
         end
         if (cmd.decode) begin
            gcd_mode_ff <= (func_ff == FN_GCD);
            done_ff     <= (func_ff == FN_GCD) && (mag(b_val) == '0);
            busy_ff     <= !halt_ff && !(a_bad || b_bad)
                           && ((func_ff == FN_DIV && b_val != '0) || func_ff == FN_GCD);
         end
         if (cmd.step) begin
            if (cnt_ff == CW'(1)) begin
               // one full division finished
               if (!gcd_mode_ff || rem_nx == '0) begin
                  done_ff <= 1'b1;
               end
            end
         end
         if (cmd.finish && !halt_ff) begin
            line_ff <= fin_jump ? (target - 1'b1) : line_inc;
            if (func_ff == FN_HALT) halt_ff <= 1'b1;
            if (fin_wrote) begin
               rf_ff[fin_dest[$clog2(NUM_REGS)-1:0]] <= fin_res;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= in_func;
         a_is_reg_ff <= in_a_is_reg;
         a_imm_ff    <= in_a_imm;
         a_reg_ff    <= in_a_reg;
         b_is_reg_ff <= in_b_is_reg;
         b_imm_ff    <= in_b_imm;
         b_reg_ff    <= in_b_reg;
      end
      if (cmd.decode) begin
         a_ff    <= a_val;
         b_ff    <= b_val;
         prod_ff <= a_val * b_val;
         bad_ff  <= a_bad || b_bad;
         mbad_ff <= (32'(a_reg_ff) >= NUM_REGS) || (32'(b_reg_ff) >= NUM_REGS);
         abad_ff <= a_bad;
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= CW'(DW);
         dvd_ff  <= mag(a_val);
         dvs_ff  <= mag(b_val);
         gx_ff   <= (mag(b_val) == '0) ? mag(a_val) : mag(b_val);
         gy_ff   <= mag(b_val);
      end
      if (cmd.step) begin
         quo_ff <= {quo_ff[DW-2:0], !trial[DW]};
         if (cnt_ff == CW'(1) && gcd_mode_ff && rem_nx != '0) begin
            // euclid: next division is y mod (x mod y)
            dvd_ff <= gy_ff;
            dvs_ff <= rem_nx;
            rem_ff <= '0;
            cnt_ff <= CW'(DW);
         end else begin
            dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
            rem_ff <= rem_nx;
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (cnt_ff == CW'(1) && gcd_mode_ff) begin
            // euclid: (x, y) <- (y, x mod y)
            gx_ff <= gy_ff;
            gy_ff <= rem_nx;
         end
      end
      if (cmd.finish) begin
         if (halt_ff) begin
            res_ff    <= '0;
            dest_ff   <= '0;
            wrote_ff  <= 1'b0;
            jumped_ff <= 1'b0;
            err_ff    <= ERR_NONE;
            next_ff   <= line_inc;
         end else begin
            res_ff    <= 32'(fin_res);
            dest_ff   <= fin_dest;
            wrote_ff  <= fin_wrote;
            jumped_ff <= fin_jump;
            err_ff    <= fin_err;
            next_ff   <= fin_jump ? target : next_inc;
         end
      end
   end

   assign out_result     = res_ff;
   assign out_dest_reg   = dest_ff;
   assign out_wrote_reg  = wrote_ff;
   assign out_next_line  = 16'(next_ff);
   assign out_jumped     = jumped_ff;
   assign out_halted     = halt_ff;
   assign out_error_code = err_ff;

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> busy_ff)
      else $error("iteration without work");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(halt_ff) && !$past(reset) |-> halt_ff)
      else $error("halt flag cleared");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> cnt_ff != '0)
      else $error("divider count underflow");
endmodule

[tb/cie_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cie_tb_if
// request and result word types used by the testbench
// ----------------------------------------------------------------------------
package cie_tb_types;
   typedef struct packed {
      logic [3:0]         func;
      logic               a_is_reg;
      logic signed [31:0] a_imm;
      logic [3:0]         a_reg;
      logic               b_is_reg;
      logic signed [31:0] b_imm;
      logic [3:0]         b_reg;
   } instr_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic [3:0]         dest_reg;
      logic               wrote_reg;
      logic [15:0]        next_line;
      logic               jumped;
      logic               halted;
      logic [1:0]         error_code;
   } exec_type;
endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed instruction stream into the execute core; a built-in
// executor predicts every result word, compared in order at the output
// ----------------------------------------------------------------------------
module tb_top;
   import cie_pkg::*;
   import cie_tb_types::*;

   localparam int NREGS = 10;
   localparam int WATCHDOG = 20000;

   logic clock = 0;
   logic reset = 1;

   cie_req_if req ();
   cie_rsp_if rsp ();

   calc_instruction_execute_core u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      forever #2 clock = ~clock;
   end

   instr_type   pending_instrs[$];
   exec_type    expected_words[$];
   logic [31:0] regs[NREGS];
   logic [15:0] line_cnt;
   logic        halt_seen;
   int          errors = 0;
   int          idle_cnt = 0;
   int          send_wait = 0;
   int          recv_wait = 0;
   int          hold_cycles = 0;
   bit          hold_req = 0;

   function automatic logic [31:0] mag(logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   function automatic logic [31:0] euclid(logic [31:0] x, logic [31:0] y);
      logic [31:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   task automatic execute_instr(instr_type w);
      exec_type    o;
      logic [31:0] a, b, q;
      logic        bad;
      o = '0;
      a = 0;
      b = 0;
      bad = 0;
      if (halt_seen) begin
         o.halted = 1;
         o.next_line = line_cnt + 16'd1;
         expected_words.push_back(o);
         return;
      end
      line_cnt = line_cnt + 16'd1;
      o.next_line = line_cnt + 16'd1;
      if (w.a_is_reg) begin
         if (w.a_reg >= NREGS) bad = 1; else a = regs[w.a_reg];
      end else a = w.a_imm;
      if (w.b_is_reg) begin
         if (w.b_reg >= NREGS) bad = 1; else b = regs[w.b_reg];
      end else b = w.b_imm;
      if (w.func <= FN_CMP) begin
         if (bad) o.error_code = ERR_INDEX;
         else begin
            o.wrote_reg = 1;
            case (w.func)
               FN_ADD: o.result = a + b;
               FN_SUB: o.result = a - b;
               FN_MUL: o.result = a * b;
               FN_DIV: begin
                  if (b == 0) begin
                     o.error_code = ERR_DIV0;
                     o.wrote_reg = 0;
                  end else begin
                     q = mag(a) / mag(b);
                     o.result = (a[31] ^ b[31]) ? -q : q;
                  end
               end
               FN_GCD: o.result = euclid(mag(a), mag(b));
               default: o.result = ($signed(a) >= $signed(b)) ? 0 : 1;
            endcase
            if (o.wrote_reg) regs[0] = o.result;
         end
      end else if (w.func == FN_MOVE) begin
         if (w.a_reg >= NREGS || w.b_reg >= NREGS) o.error_code = ERR_INDEX;
         else begin
            o.result = regs[w.b_reg];
            regs[w.a_reg] = o.result;
            o.dest_reg = w.a_reg;
            o.wrote_reg = 1;
         end
      end else if (w.func == FN_JUMP || w.func == FN_BR) begin
         if (w.a_is_reg && w.a_reg >= NREGS) o.error_code = ERR_INDEX;
         else if (w.func == FN_JUMP || regs[0] == 1) begin
            line_cnt = a[15:0] - 16'd1;
            o.next_line = a[15:0];
            o.jumped = 1;
         end
      end else if (w.func == FN_HALT) halt_seen = 1;
      o.halted = halt_seen;
      expected_words.push_back(o);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         send_wait <= $urandom_range(0, 13);
      end else if (req.valid && req.ready) begin
         execute_instr(pending_instrs.pop_front());
         req.valid <= 0;
         send_wait <= $urandom_range(0, 13);
      end else if (!req.valid) begin
         if (send_wait > 0) send_wait <= send_wait - 1;
         else if (pending_instrs.size() > 0) begin
            {req.func, req.a_is_reg, req.a_imm, req.a_reg, req.b_is_reg, req.b_imm,
             req.b_reg} <= pending_instrs[0];
            req.valid <= 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      exec_type e;
      if (reset) begin
         rsp.ready <= 0;
         recv_wait <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp.result, '0);
            end else begin
               e = expected_words.pop_front();
               if (rsp.result !== e.result) report_mismatch("result", rsp.result, e.result);
               if (rsp.dest_reg !== e.dest_reg)
                  report_mismatch("dest_reg", rsp.dest_reg, e.dest_reg);
               if (rsp.wrote_reg !== e.wrote_reg)
                  report_mismatch("wrote_reg", rsp.wrote_reg, e.wrote_reg);
               if (rsp.next_line !== e.next_line)
                  report_mismatch("next_line", rsp.next_line, e.next_line);
               if (rsp.jumped !== e.jumped) report_mismatch("jumped", rsp.jumped, e.jumped);
               if (rsp.halted !== e.halted) report_mismatch("halted", rsp.halted, e.halted);
               if (rsp.error_code !== e.error_code)
                  report_mismatch("error_code", rsp.error_code, e.error_code);
            end
         end
         if (hold_req) begin
            rsp.ready <= 0;
         end else if (rsp.valid && rsp.ready || !rsp.ready && recv_wait == 0) begin
            if (rsp.valid && rsp.ready) begin
               recv_wait <= $urandom_range(0, 13);
               rsp.ready <= 0;
            end else rsp.ready <= 1;
         end else if (!rsp.ready) recv_wait <= recv_wait - 1;
      end
   end

   // long receiver stall
   always @(posedge clock) begin
      if (reset) hold_cycles <= 0;
      else begin
         hold_cycles <= hold_cycles + 1;
         hold_req <= (hold_cycles >= 3000 && hold_cycles < 3600);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
         $display("** calc_instruction_execute_core: FAILED **");
         $finish;
      end
   end

   function automatic instr_type rand_instr(bit well_formed);
      instr_type w;
      w.func = well_formed ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 15));
      // keep halt for the last phase only
      if (!well_formed && w.func == FN_HALT) w.func = 4'd12;
      w.a_is_reg = 1'($urandom_range(0, 1));
      w.b_is_reg = 1'($urandom_range(0, 1));
      w.a_reg = well_formed ? 4'($urandom_range(0, NREGS - 1)) : 4'($urandom_range(0, 15));
      w.b_reg = well_formed ? 4'($urandom_range(0, NREGS - 1)) : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
         0: w.a_imm = $urandom;
         1: w.a_imm = $signed($urandom_range(0, 40)) - 20;
         2: w.a_imm = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: w.a_imm = $urandom_range(0, 1000);
      endcase
      case ($urandom_range(0, 3))
         0: w.b_imm = $urandom;
         1: w.b_imm = $signed($urandom_range(0, 40)) - 20;
         2: w.b_imm = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
         default: w.b_imm = $urandom_range(1, 1000);
      endcase
      return w;
   endfunction

   function automatic instr_type mk(logic [3:0] f, bit ar, logic [31:0] ai, logic [3:0] ra,
                                    bit br, logic [31:0] bi, logic [3:0] rb);
      instr_type w;
      w = '{f, ar, ai, ra, br, bi, rb};
      return w;
   endfunction

   task automatic run_phase(int n, bit with_halt);
      for (int i = 0; i < n; i++)
         pending_instrs.push_back(rand_instr($urandom_range(0, 9) != 0));
      if (with_halt) begin
         pending_instrs.push_back(mk(FN_HALT, 0, 0, 0, 0, 0, 0));
         for (int i = 0; i < 5; i++) pending_instrs.push_back(rand_instr(0));
      end
      while (pending_instrs.size() > 0 || expected_words.size() > 0) @(posedge clock);
   endtask

   initial begin
      req.func = 0; req.a_is_reg = 0; req.a_imm = 0; req.a_reg = 0;
      req.b_is_reg = 0; req.b_imm = 0; req.b_reg = 0;
      req.valid = 0;
      rsp.ready = 0;
      for (int i = 0; i < NREGS; i++) regs[i] = 0;
      line_cnt = 0;
      halt_seen = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      // directed corners
      pending_instrs.push_back(mk(FN_ADD, 0, 32'h7fff_ffff, 0, 0, 1, 0));
      pending_instrs.push_back(mk(FN_SUB, 0, 32'h8000_0000, 0, 0, 1, 0));
      pending_instrs.push_back(mk(FN_MUL, 0, 32'hffff_ffff, 0, 0, 32'h8000_0000, 0));
      pending_instrs.push_back(mk(FN_DIV, 0, 32'h8000_0000, 0, 0, 32'hffff_ffff, 0));
      pending_instrs.push_back(mk(FN_DIV, 0, -7, 0, 0, 2, 0));
      pending_instrs.push_back(mk(FN_DIV, 0, 5, 0, 0, 0, 0));
      pending_instrs.push_back(mk(FN_DIV, 1, 0, 15, 0, 0, 0));
      pending_instrs.push_back(mk(FN_GCD, 0, -12, 0, 0, 18, 0));
      pending_instrs.push_back(mk(FN_GCD, 0, 0, 0, 0, -9, 0));
      pending_instrs.push_back(mk(FN_GCD, 0, 0, 0, 0, 0, 0));
      pending_instrs.push_back(mk(FN_GCD, 0, 32'h8000_0000, 0, 0, 0, 0));
      pending_instrs.push_back(mk(FN_CMP, 0, -1, 0, 0, 1, 0));
      pending_instrs.push_back(mk(FN_MOVE, 0, 0, 9, 0, 0, 0));
      pending_instrs.push_back(mk(FN_MOVE, 0, 0, 10, 0, 0, 3));
      pending_instrs.push_back(mk(FN_BR, 0, 100, 0, 0, 0, 0));
      pending_instrs.push_back(mk(FN_JUMP, 0, 0, 0, 0, 0, 0));
      pending_instrs.push_back(mk(FN_JUMP, 1, 0, 9, 0, 0, 0));
      pending_instrs.push_back(mk(FN_JUMP, 1, 0, 12, 0, 0, 0));
      pending_instrs.push_back(mk(4'd12, 1, -1, 15, 1, -1, 15));
      pending_instrs.push_back(mk(FN_ADD, 1, 0, 11, 1, 0, 13));
      run_phase(300, 0);
      run_phase(300, 0);
      run_phase(300, 1);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("** calc_instruction_execute_core: PASSED **");
      else $display("** calc_instruction_execute_core: FAILED **");
      $finish;
   end
endmodule
